>>> rtl/fwrx_pkg.sv
`default_nettype none
package fwrx_pkg;

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_ERASE = 2'd1;
  localparam logic [1:0] FUNC_DATA  = 2'd2;

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_ERASING   = 3'd1;
  localparam logic [2:0] PH_RECEIVING = 3'd2;
  localparam logic [2:0] PH_VERIFIED  = 3'd3;
  localparam logic [2:0] PH_ERROR     = 3'd4;

  localparam logic [2:0] RP_NONE    = 3'd0;
  localparam logic [2:0] RP_STARTED = 3'd1;
  localparam logic [2:0] RP_ACK     = 3'd2;
  localparam logic [2:0] RP_DONE    = 3'd3;
  localparam logic [2:0] RP_NACK    = 3'd4;

  localparam logic       REG_MAX_IMAGE = 1'b0;
  localparam logic       REG_BASE_ADDR = 1'b1;

  localparam logic [31:0] CRC_POLY          = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES          = 32'hFFFFFFFF;
  localparam logic [31:0] DEFAULT_MAX_IMAGE = 32'(384 * 1024);
  localparam logic [31:0] DEFAULT_BASE      = 32'h08080000;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic [2:0]  reply;
    logic [2:0]  phase;
    logic        program_strobe;
    logic [31:0] flash_address;
    logic [31:0] bytes_received;
    logic [31:0] final_crc;
    logic        last;
  } result_t;

  typedef struct packed {
    logic valid;
    logic two;
  } push_t;

  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/fwrx_result_fifo.sv
`default_nettype none
module fwrx_result_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fwrx_pkg::push_t   push,
  input  wire fwrx_pkg::result_t push_res0,
  input  wire fwrx_pkg::result_t push_res1,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fwrx_pkg::result_t      head
);

  fwrx_pkg::result_t entries [fwrx_pkg::FIFO_DEPTH];
  logic [fwrx_pkg::FIFO_AW-1:0] wr_ptr;
  logic [fwrx_pkg::FIFO_AW-1:0] rd_ptr;
  logic [fwrx_pkg::FIFO_AW:0]   fill;
  logic [fwrx_pkg::FIFO_AW:0]   fill_next;
  logic                         pop;
  logic [fwrx_pkg::FIFO_AW:0]   push_n;
  logic [fwrx_pkg::FIFO_AW-1:0] wr_ptr_plus1;

  assign out_valid    = (fill != '0);
  assign pop          = out_valid && out_ready;
  assign room         = (fill <= (fwrx_pkg::FIFO_AW + 1)'(fwrx_pkg::FIFO_DEPTH - 2));
  assign head         = entries[rd_ptr];
  assign wr_ptr_plus1 = wr_ptr + 1'b1;

  always_comb begin
    push_n = '0;
    if (push.valid) begin
      push_n = push.two ? (fwrx_pkg::FIFO_AW + 1)'(2) : (fwrx_pkg::FIFO_AW + 1)'(1);
    end
    fill_next = fill + push_n - {{fwrx_pkg::FIFO_AW{1'b0}}, pop};
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push_res0;
      if (push.two) begin
        entries[wr_ptr_plus1] <= push_res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[fwrx_pkg::FIFO_AW-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fwrx_core.sv
`default_nettype none
module fwrx_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        func,
  input  wire logic [31:0]       image_size,
  input  wire logic [31:0]       expected_crc,
  input  wire logic [7:0]        data_byte,
  input  wire logic              write_ok,
  input  wire logic              frame_end,
  input  wire logic              erase_ok,
  input  wire logic              room,
  output fwrx_pkg::push_t        push,
  output fwrx_pkg::result_t      res0,
  output fwrx_pkg::result_t      res1
);

  logic [31:0] max_image_bytes;
  logic [31:0] image_base_address;

  logic        hold_valid;
  logic [1:0]  h_func;
  logic [31:0] h_size;
  logic [31:0] h_crc;
  logic [7:0]  h_byte;
  logic        h_wok;
  logic        h_fend;
  logic        h_eok;

  logic [2:0]  session_phase;
  logic [31:0] announced_size;
  logic [31:0] announced_crc;
  logic [31:0] running_crc;
  logic [31:0] byte_count;

  logic [2:0]  session_phase_next;
  logic [31:0] announced_size_next;
  logic [31:0] announced_crc_next;
  logic [31:0] running_crc_next;
  logic [31:0] byte_count_next;

  logic        fire;
  logic [31:0] crc_folded;
  logic [31:0] count_inc;
  logic [2:0]  reply0;
  logic        strobe;
  logic [31:0] addr;
  logic        two;

  assign fire     = hold_valid && room;
  assign in_ready = !hold_valid || room;

  assign crc_folded = fwrx_pkg::crc_fold_byte(running_crc, h_byte);
  assign count_inc  = (byte_count == fwrx_pkg::ALL_ONES) ? byte_count : byte_count + 32'd1;

  always_comb begin
    session_phase_next  = session_phase;
    announced_size_next = announced_size;
    announced_crc_next  = announced_crc;
    running_crc_next    = running_crc;
    byte_count_next     = byte_count;
    reply0              = fwrx_pkg::RP_NONE;
    strobe              = 1'b0;
    addr                = 32'd0;
    two                 = 1'b0;
    case (h_func)
      fwrx_pkg::FUNC_START: begin
        if (session_phase == fwrx_pkg::PH_IDLE) begin
          if (h_size != 32'd0 && h_size <= max_image_bytes) begin
            announced_size_next = h_size;
            announced_crc_next  = h_crc;
            running_crc_next    = fwrx_pkg::ALL_ONES;
            session_phase_next  = fwrx_pkg::PH_ERASING;
            reply0              = fwrx_pkg::RP_STARTED;
          end else begin
            reply0 = fwrx_pkg::RP_NACK;
          end
        end
      end
      fwrx_pkg::FUNC_ERASE: begin
        if (session_phase == fwrx_pkg::PH_ERASING) begin
          if (h_eok) begin
            byte_count_next    = 32'd0;
            session_phase_next = fwrx_pkg::PH_RECEIVING;
            reply0             = fwrx_pkg::RP_ACK;
          end else begin
            session_phase_next = fwrx_pkg::PH_ERROR;
          end
        end
      end
      fwrx_pkg::FUNC_DATA: begin
        if (session_phase == fwrx_pkg::PH_RECEIVING) begin
          strobe = 1'b1;
          addr   = image_base_address + byte_count;
          if (!h_wok) begin
            session_phase_next = fwrx_pkg::PH_ERROR;
            reply0             = fwrx_pkg::RP_NACK;
          end else begin
            running_crc_next = crc_folded;
            byte_count_next  = count_inc;
            if (h_fend) begin
              if (count_inc >= announced_size) begin
                running_crc_next = ~crc_folded;
                reply0           = fwrx_pkg::RP_DONE;
                if (~crc_folded == announced_crc) begin
                  session_phase_next = fwrx_pkg::PH_VERIFIED;
                end else begin
                  session_phase_next = fwrx_pkg::PH_ERROR;
                  two                = 1'b1;
                end
              end else begin
                reply0 = fwrx_pkg::RP_ACK;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push.valid = fire;
    push.two   = two;

    res0.reply          = reply0;
    res0.phase          = session_phase_next;
    res0.program_strobe = strobe;
    res0.flash_address  = addr;
    res0.bytes_received = byte_count_next;
    res0.final_crc      = running_crc_next;
    res0.last           = !two;

    res1.reply          = fwrx_pkg::RP_NACK;
    res1.phase          = session_phase_next;
    res1.program_strobe = 1'b0;
    res1.flash_address  = 32'd0;
    res1.bytes_received = byte_count_next;
    res1.final_crc      = running_crc_next;
    res1.last           = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      h_func <= func;
      h_size <= image_size;
      h_crc  <= expected_crc;
      h_byte <= data_byte;
      h_wok  <= write_ok;
      h_fend <= frame_end;
      h_eok  <= erase_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid         <= 1'b0;
      max_image_bytes    <= fwrx_pkg::DEFAULT_MAX_IMAGE;
      image_base_address <= fwrx_pkg::DEFAULT_BASE;
      session_phase      <= fwrx_pkg::PH_IDLE;
      announced_size     <= 32'd0;
      announced_crc      <= 32'd0;
      running_crc        <= fwrx_pkg::ALL_ONES;
      byte_count         <= 32'd0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
      end else if (fire) begin
        hold_valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          fwrx_pkg::REG_MAX_IMAGE: max_image_bytes    <= cfg_data;
          fwrx_pkg::REG_BASE_ADDR: image_base_address <= cfg_data;
          default: begin
          end
        endcase
      end
      if (fire) begin
        session_phase  <= session_phase_next;
        announced_size <= announced_size_next;
        announced_crc  <= announced_crc_next;
        running_crc    <= running_crc_next;
        byte_count     <= byte_count_next;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/firmware_image_receiver_crc32.sv
`default_nettype none
// Firmware-update session tracker with CRC32 check. Each transaction on the
// input channel (start, erase result or data byte) is captured in an input
// register and processed, once the result queue has room, by one pass of
// logic that updates the session state and folds a data byte into the
// reflected CRC32. Its one or two results go into a four-entry result
// queue, so one input transaction is taken every cycle while the output side
// keeps up; each result passes the input register and the queue. A failed
// CRC check yields two results, the second a nack. Configuration writes take
// effect at once and should be made only while no transaction is in flight.
module firmware_image_receiver_crc32 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  func,
  input  wire logic [31:0] image_size,
  input  wire logic [31:0] expected_crc,
  input  wire logic [7:0]  data_byte,
  input  wire logic        write_ok,
  input  wire logic        frame_end,
  input  wire logic        erase_ok,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       reply,
  output logic [2:0]       phase,
  output logic             program_strobe,
  output logic [31:0]      flash_address,
  output logic [31:0]      bytes_received,
  output logic [31:0]      final_crc,
  output logic             last
);

  fwrx_pkg::push_t   push;
  fwrx_pkg::result_t res0;
  fwrx_pkg::result_t res1;
  fwrx_pkg::result_t head;
  logic              room;

  fwrx_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .image_size   (image_size),
    .expected_crc (expected_crc),
    .data_byte    (data_byte),
    .write_ok     (write_ok),
    .frame_end    (frame_end),
    .erase_ok     (erase_ok),
    .room         (room),
    .push         (push),
    .res0         (res0),
    .res1         (res1)
  );

  fwrx_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_res0 (res0),
    .push_res1 (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign reply          = head.reply;
  assign phase          = head.phase;
  assign program_strobe = head.program_strobe;
  assign flash_address  = head.flash_address;
  assign bytes_received = head.bytes_received;
  assign final_crc      = head.final_crc;
  assign last           = head.last;

endmodule
`default_nettype wire

>>> bench/tb_firmware_image_receiver_crc32.sv
`timescale 1ns / 100ps

module tb_firmware_image_receiver_crc32;
  import fwrx_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int LONG_HOLD = 60;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT = 600000;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] image_size;
    logic [31:0] expected_crc;
    logic [7:0]  data_byte;
    logic        write_ok;
    logic        frame_end;
    logic        erase_ok;
  } fw_item_t;

  typedef enum logic [1:0] {
    END_VERIFIED,
    END_CRC_MISMATCH,
    END_WRITE_FAIL
  } close_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  func = '0;
  logic [31:0] image_size = '0;
  logic [31:0] expected_crc = '0;
  logic [7:0]  data_byte = '0;
  logic        write_ok = 1'b0;
  logic        frame_end = 1'b0;
  logic        erase_ok = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  reply;
  logic [2:0]  phase;
  logic        program_strobe;
  logic [31:0] flash_address;
  logic [31:0] bytes_received;
  logic [31:0] final_crc;
  logic        last;

  logic [2:0]  model_phase = PH_IDLE;
  logic [31:0] model_size = '0;
  logic [31:0] model_target_crc = '0;
  logic [31:0] model_crc = ALL_ONES;
  logic [31:0] model_count = '0;
  logic [31:0] model_max_bytes = DEFAULT_MAX_IMAGE;
  logic [31:0] model_base = DEFAULT_BASE;

  result_t     session_reports[$];
  logic [7:0]  image_bytes[$];
  logic [31:0] announced_size;
  logic [31:0] announced_crc;
  close_kind_t ending;
  string       ending_label;

  bit tx_gaps_on = 1'b1;
  bit rx_stalls_on = 1'b1;
  int hold_requests = 0;
  int holds_served = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int reg_writes = 0;

  firmware_image_receiver_crc32 dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .image_size     (image_size),
    .expected_crc   (expected_crc),
    .data_byte      (data_byte),
    .write_ok       (write_ok),
    .frame_end      (frame_end),
    .erase_ok       (erase_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .reply          (reply),
    .phase          (phase),
    .program_strobe (program_strobe),
    .flash_address  (flash_address),
    .bytes_received (bytes_received),
    .final_crc      (final_crc),
    .last           (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] crc32_shift_in(logic [31:0] crc, logic [7:0] b);
    logic [31:0] acc;
    acc = crc ^ {24'd0, b};
    repeat (8) acc = (acc >> 1) ^ (CRC_POLY & {32{acc[0]}});
    return acc;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic fw_item_t make_item(logic [1:0] f, logic [31:0] size,
                                         logic [31:0] crc, logic [7:0] b,
                                         logic wr, logic fe, logic er);
    fw_item_t it;
    it.func = f;
    it.image_size = size;
    it.expected_crc = crc;
    it.data_byte = b;
    it.write_ok = wr;
    it.frame_end = fe;
    it.erase_ok = er;
    return it;
  endfunction

  function automatic fw_item_t noise_item();
    logic [1:0] f;
    case ($urandom_range(0, 2))
      0: f = FUNC_START;
      1: f = FUNC_ERASE;
      default: f = FUNC_UNUSED;
    endcase
    return make_item(f, $urandom(), $urandom(), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
  endfunction

  function automatic void post_report(logic [2:0] rep, logic strobe,
                                      logic [31:0] addr, logic fin);
    result_t r;
    r.reply = rep;
    r.phase = model_phase;
    r.program_strobe = strobe;
    r.flash_address = strobe ? addr : 32'd0;
    r.bytes_received = model_count;
    r.final_crc = model_crc;
    r.last = fin;
    session_reports.push_back(r);
  endfunction

  function automatic void track_session(fw_item_t it);
    logic [2:0]  rep;
    logic        strobe;
    logic [31:0] addr;
    rep = RP_NONE;
    strobe = 1'b0;
    addr = '0;
    case (it.func)
      FUNC_START: begin
        if (model_phase == PH_IDLE) begin
          if (it.image_size != 0 && it.image_size <= model_max_bytes) begin
            model_size = it.image_size;
            model_target_crc = it.expected_crc;
            model_crc = ALL_ONES;
            model_phase = PH_ERASING;
            rep = RP_STARTED;
          end else begin
            rep = RP_NACK;
          end
        end
      end
      FUNC_ERASE: begin
        if (model_phase == PH_ERASING) begin
          if (it.erase_ok) begin
            model_count = '0;
            model_phase = PH_RECEIVING;
            rep = RP_ACK;
          end else begin
            model_phase = PH_ERROR;
          end
        end
      end
      FUNC_DATA: begin
        if (model_phase == PH_RECEIVING) begin
          strobe = 1'b1;
          addr = model_base + model_count;
          if (!it.write_ok) begin
            model_phase = PH_ERROR;
            rep = RP_NACK;
          end else begin
            model_crc = crc32_shift_in(model_crc, it.data_byte);
            if (model_count != ALL_ONES) model_count = model_count + 32'd1;
            if (it.frame_end) begin
              if (model_count >= model_size) begin
                model_crc = ~model_crc;
                rep = RP_DONE;
                if (model_crc == model_target_crc) begin
                  model_phase = PH_VERIFIED;
                end else begin
                  model_phase = PH_ERROR;
                  post_report(RP_DONE, strobe, addr, 1'b0);
                  post_report(RP_NACK, 1'b0, 32'd0, 1'b1);
                  return;
                end
              end else begin
                rep = RP_ACK;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    post_report(rep, strobe, addr, 1'b1);
  endfunction

  task automatic send_item(input fw_item_t it);
    int gap;
    gap = tx_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= it.func;
    image_size <= it.image_size;
    expected_crc <= it.expected_crc;
    data_byte <= it.data_byte;
    write_ok <= it.write_ok;
    frame_end <= it.frame_end;
    erase_ok <= it.erase_ok;
    do @(posedge clk); while (!in_ready);
    track_session(it);
    items_sent++;
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (session_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_MAX_IMAGE) model_max_bytes = value;
    else model_base = value;
    reg_writes++;
  endtask

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  task automatic check_report();
    result_t want;
    if (session_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP)
        $error("result with no transaction pending: reply %0d phase %0d", reply, phase);
    end else begin
      want = session_reports.pop_front();
      compare_field("reply", 32'(want.reply), 32'(reply));
      compare_field("phase", 32'(want.phase), 32'(phase));
      compare_field("program_strobe", 32'(want.program_strobe), 32'(program_strobe));
      compare_field("flash_address", want.flash_address, flash_address);
      compare_field("bytes_received", want.bytes_received, bytes_received);
      compare_field("final_crc", want.final_crc, final_crc);
      compare_field("last", 32'(want.last), 32'(last));
      results_checked++;
    end
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_report();
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && rx_stalls_on) begin
        stall_left = idle_len();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL firmware_image_receiver_crc32");
    $finish;
  end

  task automatic test_idle_replies();
    send_item(make_item(FUNC_UNUSED, $urandom(), $urandom(), 8'hFF, 1'b1, 1'b1, 1'b1));
    send_item(make_item(FUNC_ERASE, $urandom(), $urandom(), 8'h00, 1'b0, 1'b0, 1'b1));
    send_item(make_item(FUNC_DATA, $urandom(), $urandom(), 8'hFF, 1'b1, 1'b1, 1'b0));
    send_item(make_item(FUNC_DATA, $urandom(), $urandom(), 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(FUNC_START, 32'd0, ALL_ONES, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(FUNC_START, ALL_ONES, 32'd0, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_item(make_item(FUNC_START, DEFAULT_MAX_IMAGE + 32'd1, $urandom(), 8'h5A,
                        1'b1, 1'b0, 1'b1));
  endtask

  task automatic test_start_limits();
    settle_block();
    write_reg(REG_MAX_IMAGE, 32'd1);
    send_item(make_item(FUNC_START, 32'd2, $urandom(), 8'hA5, 1'b0, 1'b1, 1'b0));
    settle_block();
    write_reg(REG_MAX_IMAGE, ALL_ONES);
    send_item(make_item(FUNC_START, 32'd0, $urandom(), 8'h3C, 1'b1, 1'b0, 1'b1));
    settle_block();
    write_reg(REG_MAX_IMAGE, announced_size);
    write_reg(REG_BASE_ADDR, $urandom());
    send_item(make_item(FUNC_START, announced_size + 32'd1, announced_crc, 8'h00,
                        1'b1, 1'b1, 1'b1));
  endtask

  task automatic test_session_open();
    send_item(make_item(FUNC_START, announced_size, announced_crc,
                        8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0));
    send_item(make_item(FUNC_START, announced_size, $urandom(), 8'h00, 1'b0, 1'b0, 1'b1));
    send_item(make_item(FUNC_DATA, $urandom(), $urandom(), 8'hC3, 1'b1, 1'b1, 1'b1));
    send_item(make_item(FUNC_UNUSED, $urandom(), $urandom(), 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(make_item(FUNC_ERASE, $urandom(), $urandom(), 8'h00, 1'b0, 1'b0, 1'b1));
    send_item(make_item(FUNC_ERASE, $urandom(), $urandom(), 8'h00, 1'b1, 1'b1, 1'b0));
    send_item(make_item(FUNC_START, announced_size, announced_crc, 8'h00, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_receive_image();
    int  idx;
    int  stop;
    logic fe;
    idx = 0;
    for (int seg = 0; seg < 4; seg++) begin
      settle_block();
      case (seg)
        0: begin
          write_reg(REG_BASE_ADDR, ALL_ONES - model_count - 32'd3);
          write_reg(REG_MAX_IMAGE, 32'd1);
          tx_gaps_on = 1'b1;
          rx_stalls_on = 1'b1;
        end
        1: begin
          write_reg(REG_BASE_ADDR, 32'd0);
          write_reg(REG_MAX_IMAGE, ALL_ONES);
          tx_gaps_on = 1'b0;
          rx_stalls_on = 1'b1;
          hold_requests++;
        end
        2: begin
          write_reg(REG_BASE_ADDR, ALL_ONES);
          write_reg(REG_MAX_IMAGE, $urandom());
          tx_gaps_on = 1'b0;
          rx_stalls_on = 1'b0;
        end
        default: begin
          write_reg(REG_BASE_ADDR, $urandom());
          write_reg(REG_MAX_IMAGE, DEFAULT_MAX_IMAGE);
          tx_gaps_on = 1'b1;
          rx_stalls_on = 1'b1;
        end
      endcase
      stop = (seg == 3) ? image_bytes.size() - 1 : (seg + 1) * (image_bytes.size() / 4);
      for (; idx < stop; idx++) begin
        if ($urandom_range(0, 99) < 8) send_item(noise_item());
        fe = ($urandom_range(0, 15) == 0) && (32'(idx + 1) < announced_size);
        send_item(make_item(FUNC_DATA, $urandom(), $urandom(), image_bytes[idx],
                            1'b1, fe, 1'($urandom_range(0, 1))));
      end
    end
  endtask

  task automatic test_image_close();
    logic [7:0] tail;
    tail = image_bytes[image_bytes.size() - 1];
    if (ending == END_WRITE_FAIL)
      send_item(make_item(FUNC_DATA, $urandom(), $urandom(), tail, 1'b0,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
    else
      send_item(make_item(FUNC_DATA, $urandom(), $urandom(), tail, 1'b1, 1'b1,
                          1'($urandom_range(0, 1))));
    send_item(make_item(FUNC_START, 32'd1, $urandom(), 8'h00, 1'b1, 1'b0, 1'b1));
    repeat (4) send_item(noise_item());
    send_item(make_item(FUNC_DATA, $urandom(), $urandom(), 8'($urandom_range(0, 255)),
                        1'b1, 1'b1, 1'b1));
  endtask

  initial begin : stimulus
    int          n;
    logic [31:0] crc;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    n = $urandom_range(1080, 1110);
    for (int i = 0; i < n; i++) image_bytes.push_back(8'($urandom_range(0, 255)));
    ending = close_kind_t'($urandom_range(0, 2));
    crc = ALL_ONES;
    foreach (image_bytes[i]) crc = crc32_shift_in(crc, image_bytes[i]);
    announced_crc = ~crc;
    announced_size = 32'(n);
    case (ending)
      END_VERIFIED: begin
        announced_size = 32'(n - $urandom_range(0, 3));
        ending_label = "a matching CRC";
      end
      END_CRC_MISMATCH: begin
        announced_size = 32'(n - $urandom_range(0, 3));
        announced_crc = announced_crc ^ (32'd1 << $urandom_range(0, 31));
        ending_label = "a CRC mismatch";
      end
      default: ending_label = "a failed flash write";
    endcase

    test_idle_replies();
    test_start_limits();
    test_session_open();
    test_receive_image();
    test_image_close();

    settle_block();
    repeat (8) @(posedge clk);
    $display("Sent %0d input transactions and checked %0d results over %0d register writes.",
             items_sent, results_checked, reg_writes);
    $display("Session carried a %0d byte image and closed on %s.", n, ending_label);
    if (mismatches == 0) begin
      $display("PASS firmware_image_receiver_crc32");
    end else begin
      $display("FAIL firmware_image_receiver_crc32");
    end
    $finish;
  end

endmodule
